// ===== src/rcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrc_pkg
// Shared types, constants and helpers for the reflected CRC-32 engine.
// ----------------------------------------------------------------------------
package rcrc_pkg;

  localparam int CRC_W          = 32;
  localparam int BYTE_W         = 8;
  localparam int BYTES_PER_ITEM = 4;
  localparam int DATA_W         = BYTES_PER_ITEM * BYTE_W;
  localparam int COUNT_W        = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int SEL_W          = $clog2(BYTES_PER_ITEM + 1);

  localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] SEED_RESET = 32'hFFFF_FFFF;

  typedef logic [CRC_W-1:0]     crc_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLY_VALUE     = 2'd0,
    REG_POLY_IS_NORMAL = 2'd1,
    REG_SEED_VALUE     = 2'd2
  } cfg_reg_t;

  // Settings the datapath needs, already resolved to the reflected form.
  typedef struct packed {
    crc_t rpoly;
    crc_t seed;
  } crc_cfg_t;

  function automatic crc_t bit_reverse(input crc_t v);
    crc_t r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== src/rcrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rcrc_cfg_regs
// Configuration registers; presents the reflected polynomial and the seed.
// ----------------------------------------------------------------------------
module rcrc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  rcrc_pkg::cfg_idx_t cfg_index,
  input  rcrc_pkg::cfg_data_t cfg_wdata,
  output rcrc_pkg::crc_cfg_t cfg_o
);
  import rcrc_pkg::*;

  crc_t poly_r,   poly_nxt;
  logic normal_r, normal_nxt;
  crc_t seed_r,   seed_nxt;

  always_comb begin
    poly_nxt   = poly_r;
    normal_nxt = normal_r;
    seed_nxt   = seed_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POLY_VALUE:     poly_nxt   = cfg_wdata[CRC_W-1:0];
        REG_POLY_IS_NORMAL: normal_nxt = cfg_wdata[0];
        REG_SEED_VALUE:     seed_nxt   = cfg_wdata[CRC_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= POLY_RESET;
      normal_r <= 1'b0;
      seed_r   <= SEED_RESET;
    end else begin
      poly_r   <= poly_nxt;
      normal_r <= normal_nxt;
      seed_r   <= seed_nxt;
    end
  end

  assign cfg_o.rpoly = normal_r ? bit_reverse(poly_r) : poly_r;
  assign cfg_o.seed  = seed_r;

endmodule

// ===== src/rcrc_byte_fold.sv =====
// ----------------------------------------------------------------------------
// rcrc_byte_fold
// Folds one byte into the CRC, LSB first, eight shift-and-xor steps.
// ----------------------------------------------------------------------------
module rcrc_byte_fold (
  input  rcrc_pkg::crc_t            crc_i,
  input  logic [rcrc_pkg::BYTE_W-1:0] byte_i,
  input  rcrc_pkg::crc_t            rpoly_i,
  output rcrc_pkg::crc_t            crc_o
);
  import rcrc_pkg::*;

  always_comb begin
    crc_t c;
    c = crc_i ^ {{(CRC_W-BYTE_W){1'b0}}, byte_i};
    for (int b = 0; b < BYTE_W; b++) begin
      c = (c >> 1) ^ (rpoly_i & {CRC_W{c[0]}});
    end
    crc_o = c;
  end

endmodule

// ===== src/rcrc_datapath.sv =====
// ----------------------------------------------------------------------------
// rcrc_datapath
// Chains one byte folder per byte lane and picks the tap set by the count.
// ----------------------------------------------------------------------------
module rcrc_datapath (
  input  rcrc_pkg::crc_t     crc_i,
  input  rcrc_pkg::crc_cfg_t cfg_i,
  input  rcrc_pkg::data_t    data_word_i,
  input  rcrc_pkg::count_t   byte_count_i,
  input  logic               restart_i,
  output rcrc_pkg::crc_t     crc_o
);
  import rcrc_pkg::*;

  crc_t             chain [0:BYTES_PER_ITEM];
  logic [SEL_W-1:0] sel;

  assign chain[0] = restart_i ? cfg_i.seed : crc_i;

  for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
    rcrc_byte_fold u_fold (
      .crc_i   (chain[k]),
      .byte_i  (data_word_i[k*BYTE_W +: BYTE_W]),
      .rpoly_i (cfg_i.rpoly),
      .crc_o   (chain[k+1])
    );
  end

  // Counts beyond the lane count saturate to a full word.
  always_comb begin
    if (32'(byte_count_i) > BYTES_PER_ITEM) begin
      sel = SEL_W'(BYTES_PER_ITEM);
    end else begin
      sel = SEL_W'(byte_count_i);
    end
  end

  assign crc_o = chain[sel];

endmodule

// ===== src/reflected_crc32_engine_unit.sv =====
// ----------------------------------------------------------------------------
// reflected_crc32_engine_unit
// Running reflected CRC-32 with programmable polynomial and seed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries up to four bytes, low byte
//   first, a byte count and a restart flag. Restart loads the seed before
//   the bytes are folded. Each transaction yields one result transaction on
//   the output channel (out_valid/out_stall) with the CRC after that item,
//   with no final XOR.
//   An item taken is held in the input register, and its result is
//   written to the result register as it moves on. Throughput is one
//   item per cycle while the receiver does not stall, set by the
//   byte-fold network between them, which also updates the running CRC.
//   While the receiver stalls, the result register holds and the input
//   register can still take one more item; after that in_stall rises.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while
//   the block is idle. Reset restores the default polynomial and seed,
//   clears the running CRC to zero and empties both registers.
// ----------------------------------------------------------------------------
module reflected_crc32_engine_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  rcrc_pkg::cfg_idx_t  cfg_index,
  input  rcrc_pkg::cfg_data_t cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  rcrc_pkg::data_t     in_data_word,
  input  rcrc_pkg::count_t    in_byte_count,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_stall,
  output rcrc_pkg::crc_t      out_crc_value
);
  import rcrc_pkg::*;

  crc_cfg_t cfg;

  logic   s1_valid_r, s1_valid_nxt;
  data_t  s1_data_r;
  count_t s1_count_r;
  logic   s1_restart_r;

  logic   out_valid_r, out_valid_nxt;
  crc_t   out_crc_r;
  crc_t   crc_r;
  crc_t   crc_nxt;

  logic   in_take;
  logic   out_adv;

  rcrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  rcrc_datapath u_dp (
    .crc_i        (crc_r),
    .cfg_i        (cfg),
    .data_word_i  (s1_data_r),
    .byte_count_i (s1_count_r),
    .restart_i    (s1_restart_r),
    .crc_o        (crc_nxt)
  );

  // The item moves on when the result register is empty or being taken.
  assign out_adv  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (out_adv) begin
        crc_r <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r    <= in_data_word;
      s1_count_r   <= in_byte_count;
      s1_restart_r <= in_restart;
    end
    if (out_adv) begin
      out_crc_r <= crc_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

// ===== tb/reflected_crc32_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// reflected_crc32_engine_unit_tb
// Self-checking bench for the running reflected CRC-32 engine.
// Items go in over the valid/stall input channel, and a tracker class folds
// them into its own CRC register to predict every result. The run has seven
// phases; each loads a polynomial, polynomial form, seed and pattern of
// sender gaps and receiver stalls. Most stimulus is restart-framed messages;
// the rest is noise with odd byte counts and stray restarts.
// ----------------------------------------------------------------------------
module reflected_crc32_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcrc_pkg::*;

  localparam int NUM_PHASES     = 7;
  localparam int ITEMS_PER_PASS = 190;
  localparam int DRAIN_CYCLES   = 5;
  localparam int MAX_REPORTS    = 100;

  // Holds the block's settings and running CRC, and queues the CRC that each
  // accepted transaction should return.
  class crc_tracker;
    crc_t poly_reg;
    logic poly_normal;
    crc_t seed_reg;
    crc_t running_crc;
    crc_t expected_crc_q[$];
    int   errors;
    int   items_in;
    int   results_out;
    int   restarts;
    int   count_seen[8];

    function new();
      poly_reg    = 32'hEDB8_8320;
      poly_normal = 1'b0;
      seed_reg    = 32'hFFFF_FFFF;
      running_crc = '0;
    endfunction

    function void set_reg(cfg_reg_t idx, cfg_data_t value);
      case (idx)
        REG_POLY_VALUE:     poly_reg = value;
        REG_POLY_IS_NORMAL: poly_normal = value[0];
        REG_SEED_VALUE:     seed_reg = value;
        default: ;
      endcase
    endfunction

    function crc_t mirror(crc_t v);
      crc_t r;
      r = '0;
      for (int i = 0; i < CRC_W; i++) begin
        r = {r[CRC_W-2:0], v[i]};
      end
      return r;
    endfunction

    // Folds the valid bytes of one word into the running register, lowest
    // byte first, one bit at a time.
    function crc_t fold_word(crc_t start, data_t word, int nbytes, crc_t rpoly);
      crc_t c;
      c = start;
      for (int k = 0; k < nbytes; k++) begin
        c[7:0] = c[7:0] ^ word[8*k +: 8];
        for (int b = 0; b < 8; b++) begin
          c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
        end
      end
      return c;
    endfunction

    function void note_input(data_t word, count_t count, logic restart);
      crc_t rpoly;
      int   nbytes;
      rpoly  = poly_normal ? mirror(poly_reg) : poly_reg;
      // Counts beyond the word width saturate.
      nbytes = (count > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(count);
      running_crc = fold_word(restart ? seed_reg : running_crc, word, nbytes, rpoly);
      expected_crc_q.push_back(running_crc);
      items_in++;
      count_seen[count]++;
      if (restart) restarts++;
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(crc_t got);
      crc_t want;
      results_out++;
      if (expected_crc_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result crc_value=%08h", got));
      end else begin
        want = expected_crc_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("result %0d crc_value=%08h, expected %08h",
                                    results_out, got, want));
      end
    endtask

    function int pending();
      return expected_crc_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  data_t     in_data_word = '0;
  count_t    in_byte_count = '0;
  logic      in_restart = 1'b0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  crc_t      out_crc_value;

  int tx_gap_pct = 0;
  int rx_stall_pct = 0;

  crc_tracker tracker = new();

  reflected_crc32_engine_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_restart    (in_restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Values read here are those from before the edge, so the order of
  // processes within the time step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_input(in_data_word, in_byte_count, in_restart);
      if (out_valid && !out_stall) tracker.check_result(out_crc_value);
    end
  end

  task automatic write_reg(cfg_reg_t idx, cfg_data_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_item(data_t word, count_t count, logic restart);
    in_valid      <= 1'b1;
    in_data_word  <= word;
    in_byte_count <= count;
    in_restart    <= restart;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_gap_pct);
    end
  endtask

  // Holds the sender back until every transaction has returned its result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic data_t random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // A restart-framed message: full words, then a last word of 1 to 4 bytes.
  task automatic send_message();
    int len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      send_item(random_word(), (i == len - 1) ? count_t'($urandom_range(1, 4)) : count_t'(4),
                i == 0);
    end
  endtask

  task automatic send_noise();
    send_item(random_word(), count_t'($urandom_range(0, 7)), $urandom_range(3) == 0);
  endtask

  task automatic load_config(int phase);
    cfg_data_t poly;
    cfg_data_t normal;
    cfg_data_t seed;
    case (phase)
      0:       begin poly = 32'hEDB8_8320; normal = 0; seed = 32'hFFFF_FFFF; end
      1:       begin poly = 32'h1EDC_6F41; normal = 1; seed = 32'hFFFF_FFFF; end
      2:       begin poly = 32'h82F6_3B78; normal = 0; seed = 32'h0000_0000; end
      3:       begin poly = 32'hFFFF_FFFF; normal = 1; seed = 32'hFFFF_FFFF; end
      4:       begin poly = 32'h0000_0000; normal = 0; seed = 32'h8000_0000; end
      5:       begin poly = $urandom();    normal = $urandom(); seed = $urandom(); end
      default: begin poly = 32'h04C1_1DB7; normal = 1; seed = 32'h0000_0000; end
    endcase
    write_reg(REG_POLY_VALUE, poly);
    write_reg(REG_POLY_IS_NORMAL, normal);
    write_reg(REG_SEED_VALUE, seed);
  endtask

  initial begin
    int tx_pct[NUM_PHASES] = '{0, 59, 0, 19, 59, 0, 19};
    int rx_pct[NUM_PHASES] = '{0, 0, 59, 19, 0, 59, 19};
    int target;
    bit paused;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset settings, starting from a register of
    // zero since nothing has restarted it yet.
    send_item(32'h0000_0000, 3'd4, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd4, 1'b0);
    send_item(32'h1234_5678, 3'd0, 1'b1);
    send_item(32'hDEAD_BEEF, 3'd0, 1'b0);
    send_item(32'h3433_3231, 3'd4, 1'b1);
    send_item(32'h3837_3635, 3'd4, 1'b0);
    send_item(32'h0000_0039, 3'd1, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd5, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd6, 1'b0);
    send_item(32'hA5A5_A5A5, 3'd7, 1'b0);
    send_item(32'hA5A5_A5A5, 3'd1, 1'b1);
    send_item(32'h5A5A_5A5A, 3'd2, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd3, 1'b0);
    send_item(32'h8000_0000, 3'd4, 1'b1);
    send_item(32'h0000_0001, 3'd4, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd4, 1'b1);
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      load_config(phase);
      tx_gap_pct   = tx_pct[phase];
      rx_stall_pct = rx_pct[phase];
      target = tracker.items_in + ITEMS_PER_PASS;
      paused = 1'b0;
      // The running register carries over the settings change.
      send_item(random_word(), 3'd4, 1'b0);
      while (tracker.items_in < target) begin
        if ($urandom_range(9) < 8) send_message();
        else send_noise();
        if (!paused && tracker.items_in > target - ITEMS_PER_PASS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    $display("Covered %0d transactions (%0d with restart) over %0d settings phases.",
             tracker.items_in, tracker.restarts, NUM_PHASES);
    $display("Byte counts 0..7 seen: %0d %0d %0d %0d %0d %0d %0d %0d; %0d results checked.",
             tracker.count_seen[0], tracker.count_seen[1], tracker.count_seen[2],
             tracker.count_seen[3], tracker.count_seen[4], tracker.count_seen[5],
             tracker.count_seen[6], tracker.count_seen[7], tracker.results_out);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding.", tracker.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
src/rcrc_pkg.sv
src/rcrc_cfg_regs.sv
src/rcrc_byte_fold.sv
src/rcrc_datapath.sv
src/reflected_crc32_engine_unit.sv
tb/reflected_crc32_engine_unit_tb.sv
